// File: rtl/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // parser phase codes
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_EXT16   = 3'd1;
    localparam logic [2:0] PH_EXT64   = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [3:0] OP_CONTINUATION = 4'h0;

    localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
    localparam logic [7:0] HDR_OP_MASK  = 8'h0F;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [31:0] MAX_LEN_RESET = 32'd268435456;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       byte_valid;
        logic       start;
        logic       last;
        logic       err;
    } wsd_result_t;

endpackage
`default_nettype wire

// File: rtl/wsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header, extended length and mask key parser with payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  in_byte,
    input  wire logic [31:0] max_len,
    output wsd_result_t      res
);

    logic [2:0]  phase_reg,      phase_next;
    logic [3:0]  fcount_reg,     fcount_next;
    logic [7:0]  hdr_first_reg,  hdr_first_next;
    logic [63:0] frame_len_reg,  frame_len_next;
    logic [63:0] pay_count_reg,  pay_count_next;
    logic        fin_reg,        fin_next;
    logic        masked_reg,     masked_next;
    logic [3:0]  op_reg,         op_next;
    logic [3:0]  dmsg_op_reg,    dmsg_op_next;
    logic [31:0] mask_key_reg,   mask_key_next;
    logic [31:0] dmsg_len_reg,   dmsg_len_next;
    logic        dmsg_open_reg,  dmsg_open_next;
    logic        failed_reg,     failed_next;

    logic        is_ctrl;
    logic [3:0]  eff_op;
    logic        len_done;
    logic        start_pay;
    logic [3:0]  fcount_inc;
    logic [6:0]  len7;
    logic        over_cap;
    logic        eof;
    logic [7:0]  key_byte;
    logic [3:0]  eff_op_n;

    assign is_ctrl    = op_reg[3];
    assign eff_op     = (!is_ctrl && op_reg == OP_CONTINUATION) ? dmsg_op_reg : op_reg;
    assign fcount_inc = fcount_reg + 4'd1;
    assign len7       = in_byte[6:0] & HDR_LEN_MASK[6:0];
    assign over_cap   = is_ctrl ? (pay_count_reg >= {32'd0, max_len})
                                : (dmsg_len_reg >= max_len);
    assign key_byte   = 8'(mask_key_reg >> {pay_count_reg[1:0], 3'b000});

    always_comb
    begin
        phase_next     = phase_reg;
        fcount_next    = fcount_reg;
        hdr_first_next = hdr_first_reg;
        frame_len_next = frame_len_reg;
        pay_count_next = pay_count_reg;
        fin_next       = fin_reg;
        masked_next    = masked_reg;
        op_next        = op_reg;
        dmsg_op_next   = dmsg_op_reg;
        mask_key_next  = mask_key_reg;
        dmsg_len_next  = dmsg_len_reg;
        dmsg_open_next = dmsg_open_reg;
        failed_next    = failed_reg;
        len_done       = 1'b0;
        start_pay      = 1'b0;
        eof            = 1'b0;
        eff_op_n       = 4'd0;
        res            = '0;

        if (in_valid && !failed_reg)
        begin
            case (phase_reg)
                PH_EXT16, PH_EXT64:
                begin
                    frame_len_next = {frame_len_reg[55:0], in_byte};
                    fcount_next    = fcount_inc;
                    if (fcount_inc >= ((phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                    begin
                        len_done = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    mask_key_next = mask_key_reg
                                  | ({24'd0, in_byte} << {fcount_reg[1:0], 3'b000});
                    fcount_next   = fcount_inc;
                    if (fcount_inc >= KEY_BYTES)
                    begin
                        start_pay = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (over_cap)
                    begin
                        failed_next = 1'b1;
                        res.valid   = 1'b1;
                        res.opcode  = eff_op;
                        res.err     = 1'b1;
                    end
                    else
                    begin
                        pay_count_next = pay_count_reg + 64'd1;
                        eof            = (pay_count_next == frame_len_reg);
                        res.valid      = 1'b1;
                        res.data       = in_byte ^ (masked_reg ? key_byte : 8'd0);
                        res.opcode     = eff_op;
                        res.byte_valid = 1'b1;
                        if (is_ctrl)
                        begin
                            res.start = (pay_count_reg == 64'd0);
                            res.last  = eof;
                        end
                        else
                        begin
                            dmsg_len_next  = dmsg_len_reg + 32'd1;
                            res.start      = !dmsg_open_reg;
                            res.last       = eof && fin_reg;
                            dmsg_open_next = !res.last;
                        end
                        if (eof)
                        begin
                            phase_next  = PH_HEADER;
                            fcount_next = 4'd0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (fcount_reg == 4'd0)
                    begin
                        hdr_first_next = in_byte;
                        fcount_next    = 4'd1;
                    end
                    else
                    begin
                        fin_next    = |(hdr_first_reg & HDR_TOP_BIT);
                        op_next     = 4'(hdr_first_reg & HDR_OP_MASK);
                        masked_next = |(in_byte & HDR_TOP_BIT);
                        // a new data frame opens a fresh message
                        if (op_next != OP_CONTINUATION && !op_next[3])
                        begin
                            dmsg_op_next   = op_next;
                            dmsg_len_next  = 32'd0;
                            dmsg_open_next = 1'b0;
                        end
                        pay_count_next = 64'd0;
                        fcount_next    = 4'd0;
                        if (len7 < LEN_CODE_16)
                        begin
                            frame_len_next = {57'd0, len7};
                            len_done       = 1'b1;
                        end
                        else
                        begin
                            frame_len_next = 64'd0;
                            phase_next     = (len7 == LEN_CODE_16) ? PH_EXT16 : PH_EXT64;
                        end
                    end
                end
            endcase

            if (len_done)
            begin
                fcount_next = 4'd0;
                if (masked_next)
                begin
                    mask_key_next = 32'd0;
                    phase_next    = PH_MASK;
                end
                else
                begin
                    start_pay = 1'b1;
                end
            end

            if (start_pay)
            begin
                fcount_next    = 4'd0;
                pay_count_next = 64'd0;
                if (frame_len_next == 64'd0)
                begin
                    // empty frame completes at once
                    phase_next = PH_HEADER;
                    eff_op_n   = (!op_next[3] && op_next == OP_CONTINUATION) ? dmsg_op_next
                                                                              : op_next;
                    if (op_next[3])
                    begin
                        res.valid  = 1'b1;
                        res.opcode = op_next;
                        res.start  = 1'b1;
                        res.last   = 1'b1;
                    end
                    else if (fin_next)
                    begin
                        res.valid      = 1'b1;
                        res.opcode     = eff_op_n;
                        res.start      = !dmsg_open_next;
                        res.last       = 1'b1;
                        dmsg_open_next = 1'b0;
                    end
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fcount_reg    <= 4'd0;
            hdr_first_reg <= 8'd0;
            frame_len_reg <= 64'd0;
            pay_count_reg <= 64'd0;
            fin_reg       <= 1'b0;
            masked_reg    <= 1'b0;
            op_reg        <= 4'd0;
            dmsg_op_reg   <= 4'd0;
            mask_key_reg  <= 32'd0;
            dmsg_len_reg  <= 32'd0;
            dmsg_open_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fcount_reg    <= fcount_next;
            hdr_first_reg <= hdr_first_next;
            frame_len_reg <= frame_len_next;
            pay_count_reg <= pay_count_next;
            fin_reg       <= fin_next;
            masked_reg    <= masked_next;
            op_reg        <= op_next;
            dmsg_op_reg   <= dmsg_op_next;
            mask_key_reg  <= mask_key_next;
            dmsg_len_reg  <= dmsg_len_next;
            dmsg_open_reg <= dmsg_open_next;
            failed_reg    <= failed_next;
        end
    end

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("error flag cleared without reset");

    a_silent_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !res.valid)
        else $error("result produced after length error");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.byte_valid && !res.err) |-> res.last)
        else $error("empty result that does not end a message");

endmodule
`default_nettype wire

// File: rtl/websocket_frame_deframer_top.sv
// A result appears on the master side in the cycle after the request that
// causes it is taken. Throughput: one byte per cycle; the slave side
// stalls only while a held result is not taken, set by the single output
// register. Reset (rst_n low, asynchronous) returns the parser to the header
// phase, clears the error flag and sets max_message_len to 268435456.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Byte stream frame deframer with output register and length cap register.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,      // max_message_len
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] payload_byte
    // [3:0] msg_opcode, [4] byte_valid, [5] message_start, [6] too_long_error, [7] zero
    output logic [7:0]       m_axis_tuser,
    output logic             m_axis_tlast    // message_last
);

    logic [31:0] max_len_reg;
    wsd_result_t res;
    wsd_result_t out_reg;
    logic        accept;

    assign s_axis_tready = !out_reg.valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    wsd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_byte  (s_axis_tdata),
        .max_len  (max_len_reg),
        .res      (res)
    );

    // hold the result until taken; load a new one when the slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (s_axis_tready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tdata  = out_reg.data;
    assign m_axis_tuser  = {1'b0, out_reg.err, out_reg.start, out_reg.byte_valid,
                            out_reg.opcode};
    assign m_axis_tlast  = out_reg.last;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_error_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[6]) |->
            (!m_axis_tuser[4] && !m_axis_tuser[5] && !m_axis_tlast))
        else $error("error result carries data flags");

    a_no_load_without_request: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid && !s_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared with no request taken");

endmodule
`default_nettype wire
